@@ sv/sefr_pkg.sv @@
package sefr_pkg;

    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDataWidth = 16;

    typedef logic [CfgIdxWidth-1:0] t_cfg_idx;
    typedef logic [CfgDataWidth-1:0] t_cfg_data;
    typedef logic [2:0] t_phase;
    typedef logic [2:0] t_kind;

    localparam t_cfg_idx CFG_START_MARKER = 2'd0;
    localparam t_cfg_idx CFG_END_MARKER = 2'd1;
    localparam t_cfg_idx CFG_MAX_LENGTH = 2'd2;

    localparam logic [7:0] START_MARKER_RESET = 8'h02;
    localparam logic [7:0] END_MARKER_RESET = 8'h03;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

    localparam logic [15:0] CHECK_BYTES = 16'd4;

    localparam t_phase PH_HUNT = 3'd0;
    localparam t_phase PH_TYPE = 3'd1;
    localparam t_phase PH_LEN_HI = 3'd2;
    localparam t_phase PH_LEN_LO = 3'd3;
    localparam t_phase PH_PAYLOAD = 3'd4;
    localparam t_phase PH_CHECK = 3'd5;
    localparam t_phase PH_TRAILER = 3'd6;

    localparam t_kind KIND_IGNORED = 3'd0;
    localparam t_kind KIND_START = 3'd1;
    localparam t_kind KIND_TYPE = 3'd2;
    localparam t_kind KIND_LENGTH = 3'd3;
    localparam t_kind KIND_PAYLOAD = 3'd4;
    localparam t_kind KIND_CHECK = 3'd5;
    localparam t_kind KIND_TRAILER = 3'd6;

endpackage

@@ sv/sefr_if.sv @@
interface sefr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sefr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_end;
    logic        frame_ok;
    logic        length_error;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [31:0] frame_check;

    modport source (
        output valid, output byte_kind, output payload_byte, output payload_index,
        output frame_end, output frame_ok, output length_error, output frame_type,
        output frame_length, output frame_check, input ready
    );
    modport sink (
        input valid, input byte_kind, input payload_byte, input payload_index,
        input frame_end, input frame_ok, input length_error, input frame_type,
        input frame_length, input frame_check, output ready
    );
endinterface

@@ sv/stx_etx_length_frame_receiver.sv @@
// The result of an input transfer is held in the output register from the next cycle on.
// Throughput: one byte per cycle; a new byte is taken whenever the output register
// is empty or its result is being taken in the same cycle.
// Reset (synchronous, active low) returns to hunting for the start marker, clears
// the held frame fields and restores the marker and length limit registers.
module stx_etx_length_frame_receiver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  sefr_pkg::t_cfg_idx   i_cfg_idx,
    input  sefr_pkg::t_cfg_data  i_cfg_wdata,
    sefr_in_if.sink              i_rx,
    sefr_out_if.source           o_res
);
    import sefr_pkg::*;

    logic [7:0]  r_start_marker;
    logic [7:0]  r_end_marker;
    logic [15:0] r_max_length;

    t_phase      r_phase, n_phase;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_length, n_length;
    logic [31:0] r_check, n_check;
    logic [15:0] r_position, n_position;

    t_kind       n_kind;
    logic [7:0]  n_pbyte;
    logic [15:0] n_pidx;
    logic        n_fend, n_fok, n_lerr;
    logic [15:0] w_len_full;
    logic [15:0] w_left_dec;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_pbyte;
    logic [15:0] r_pidx;
    logic        r_fend, r_fok, r_lerr;
    logic [7:0]  r_out_type;
    logic [15:0] r_out_length;
    logic [31:0] r_out_check;

    logic        w_accept;
    logic [7:0]  w_byte;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_accept = i_rx.valid && i_rx.ready;
    assign w_byte = i_rx.rx_byte;

    assign w_len_full = {r_length[15:8], w_byte};
    assign w_left_dec = r_bytes_left - 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RESET;
            r_end_marker <= END_MARKER_RESET;
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata[7:0];
                CFG_END_MARKER: r_end_marker <= i_cfg_wdata[7:0];
                CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_bytes_left = r_bytes_left;
        n_type = r_type;
        n_length = r_length;
        n_check = r_check;
        n_position = r_position;
        n_kind = KIND_IGNORED;
        n_pbyte = 8'd0;
        n_pidx = 16'd0;
        n_fend = 1'b0;
        n_fok = 1'b0;
        n_lerr = 1'b0;
        unique case (r_phase)
            PH_TYPE: begin
                n_kind = KIND_TYPE;
                n_type = w_byte;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_kind = KIND_LENGTH;
                n_length = {w_byte, 8'd0};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_kind = KIND_LENGTH;
                n_length = w_len_full;
                if (w_len_full > r_max_length) begin
                    n_fend = 1'b1;
                    n_lerr = 1'b1;
                    n_phase = PH_HUNT;
                end else if (w_len_full == 16'd0) begin
                    n_bytes_left = CHECK_BYTES;
                    n_phase = PH_CHECK;
                end else begin
                    n_bytes_left = w_len_full;
                    n_position = 16'd0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_kind = KIND_PAYLOAD;
                n_pbyte = w_byte;
                n_pidx = r_position;
                n_position = r_position + 16'd1;
                n_bytes_left = w_left_dec;
                if (w_left_dec == 16'd0) begin
                    n_bytes_left = CHECK_BYTES;
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_kind = KIND_CHECK;
                n_check = {r_check[23:0], w_byte};
                n_bytes_left = w_left_dec;
                if (w_left_dec == 16'd0) begin
                    n_phase = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                n_kind = KIND_TRAILER;
                n_fend = 1'b1;
                n_fok = (w_byte == r_end_marker);
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
                if (w_byte == r_start_marker) begin
                    n_kind = KIND_START;
                    n_type = 8'd0;
                    n_length = 16'd0;
                    n_check = 32'd0;
                    n_bytes_left = 16'd0;
                    n_position = 16'd0;
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_bytes_left <= 16'd0;
            r_type <= 8'd0;
            r_length <= 16'd0;
            r_check <= 32'd0;
            r_position <= 16'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_type <= n_type;
            r_length <= n_length;
            r_check <= n_check;
            r_position <= n_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= n_kind;
            r_pbyte <= n_pbyte;
            r_pidx <= n_pidx;
            r_fend <= n_fend;
            r_fok <= n_fok;
            r_lerr <= n_lerr;
            r_out_type <= n_type;
            r_out_length <= n_length;
            r_out_check <= n_check;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.byte_kind = r_kind;
    assign o_res.payload_byte = r_pbyte;
    assign o_res.payload_index = r_pidx;
    assign o_res.frame_end = r_fend;
    assign o_res.frame_ok = r_fok;
    assign o_res.length_error = r_lerr;
    assign o_res.frame_type = r_out_type;
    assign o_res.frame_length = r_out_length;
    assign o_res.frame_check = r_out_check;

    // A length error ends the frame on the second length byte.
    a_lerr_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_lerr |-> r_fend && (r_kind == KIND_LENGTH))
        else $error("length error without frame end on a length byte");

    // A good frame is reported only on the trailer byte.
    a_ok_on_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fok |-> r_fend && (r_kind == KIND_TRAILER))
        else $error("frame_ok outside a trailer result");

    // The check phase always has one to four bytes to go.
    a_check_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CHECK |-> (r_bytes_left != 16'd0) && (r_bytes_left <= CHECK_BYTES))
        else $error("check byte count out of range");

    // The payload phase never runs with nothing left.
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != 16'd0)
        else $error("payload phase with zero bytes left");

endmodule
